/* hdl/nzcsb_pkg.sv */
// Package for the nonzero count sketch builder: field widths, types,
// configuration register indexes and parameter defaults. No dependencies.
`default_nettype none

package nzcsb_pkg;

    localparam int IDX_W     = 10;
    localparam int OUT_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_ROWS = 1024;
    localparam int DEF_COLS = 1024;

    // Addressable span of a 10-bit index.
    localparam int IDX_SPAN = 2 ** IDX_W;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [OUT_W-1:0]     t_out;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ROWS_IN_USE = 1'd0;
    localparam t_cfg_idx CFG_COLS_IN_USE = 1'd1;

    localparam t_cfg CFG_RESET_VALUE = 11'd1024;

endpackage

`default_nettype wire

/* hdl/nzcsb_in_if.sv */
// Input channel of the sketch builder: one nonzero entry per item.
// Depends on nzcsb_pkg.
`default_nettype none

interface nzcsb_in_if;
    logic               valid;
    logic               ready;
    nzcsb_pkg::t_idx    row_index;
    nzcsb_pkg::t_idx    col_index;

    modport source (output valid, output row_index, output col_index, input ready);
    modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

`default_nettype wire

/* hdl/nzcsb_out_if.sv */
// Result channel of the sketch builder: updated counts, totals and maxima.
// Depends on nzcsb_pkg.
`default_nettype none

interface nzcsb_out_if;
    logic               valid;
    logic               ready;
    nzcsb_pkg::t_out    row_count;
    nzcsb_pkg::t_out    col_count;
    nzcsb_pkg::t_out    rows_nonzero;
    nzcsb_pkg::t_out    cols_nonzero;
    nzcsb_pkg::t_out    max_row_count;
    nzcsb_pkg::t_out    max_col_count;
    logic               index_error;

    modport source (output valid, output row_count, output col_count,
                    output rows_nonzero, output cols_nonzero,
                    output max_row_count, output max_col_count,
                    output index_error, input ready);
    modport sink   (input valid, input row_count, input col_count,
                    input rows_nonzero, input cols_nonzero,
                    input max_row_count, input max_col_count,
                    input index_error, output ready);
endinterface

`default_nettype wire

/* hdl/nzcsb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module nzcsb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/nonzero_count_sketch_builder_unit.sv */
// Top level of the nonzero count sketch builder: row and column count RAMs,
// read-modify-write stage with forwarding, totals, maxima and result register.
// Depends on nzcsb_pkg, nzcsb_in_if, nzcsb_out_if and nzcsb_ram.
//
//   Channel    Direction  Handshake        Payload
//   i_item     in         valid / ready    row_index, col_index
//   o_result   out        valid / ready    counts, totals, maxima, index_error
//   i_cfg_*    in         write enable     register index, data
//
// One item per cycle sustained while results are taken; an accepted item passes the update
// stage register, then the result register (the RAM read is taken with the item, the update
// lands in the result register). After reset the count RAMs are zeroed one entry per cycle
// up to the larger store depth, with the input not ready meanwhile.
// A stalled result holds the update stage; the input then waits with it.
`default_nettype none

module nonzero_count_sketch_builder_unit #(
    parameter int ROWS = nzcsb_pkg::DEF_ROWS,
    parameter int COLS = nzcsb_pkg::DEF_COLS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire nzcsb_pkg::t_cfg_idx     i_cfg_index,
    input  wire nzcsb_pkg::t_cfg         i_cfg_data,
    nzcsb_in_if.sink                     i_item,
    nzcsb_out_if.source                  o_result
);

    // Only the first 2**IDX_W entries of each store can ever be addressed.
    localparam int ROW_DEPTH = (ROWS < nzcsb_pkg::IDX_SPAN) ? ROWS : nzcsb_pkg::IDX_SPAN;
    localparam int COL_DEPTH = (COLS < nzcsb_pkg::IDX_SPAN) ? COLS : nzcsb_pkg::IDX_SPAN;
    localparam int CLR_DEPTH = (ROW_DEPTH > COL_DEPTH) ? ROW_DEPTH : COL_DEPTH;
    localparam int RAW       = $clog2(ROW_DEPTH);
    localparam int CAW       = $clog2(COL_DEPTH);
    localparam int CLRW      = $clog2(CLR_DEPTH);
    // A row holds at most COLS nonzeros, a column at most ROWS.
    localparam int RCW       = $clog2(COLS + 1);
    localparam int CCW       = $clog2(ROWS + 1);

    localparam logic [RCW-1:0]  ROW_BOUND = RCW'(COLS);
    localparam logic [CCW-1:0]  COL_BOUND = CCW'(ROWS);
    localparam logic [CLRW-1:0] CLR_LAST  = CLRW'(CLR_DEPTH - 1);

    // Configuration.
    nzcsb_pkg::t_cfg r_rows_in_use;
    nzcsb_pkg::t_cfg r_cols_in_use;

    // Clearing pass.
    logic            r_clearing;
    logic [CLRW-1:0] r_clr_addr;

    // Update stage.
    logic           r_s1_valid;
    logic           r_s1_ok;
    logic [RAW-1:0] r_s1_row;
    logic [CAW-1:0] r_s1_col;

    // Last pipeline write to each RAM, for a read that overlapped it.
    logic           r_fwd_row_vld;
    logic [RAW-1:0] r_fwd_row_addr;
    logic [RCW-1:0] r_fwd_row_data;
    logic           r_fwd_col_vld;
    logic [CAW-1:0] r_fwd_col_addr;
    logic [CCW-1:0] r_fwd_col_data;

    // Totals and maxima.
    nzcsb_pkg::t_out r_rows_nz;
    nzcsb_pkg::t_out r_cols_nz;
    logic [RCW-1:0]  r_max_row;
    logic [CCW-1:0]  r_max_col;

    // Result register.
    logic            r_out_valid;
    nzcsb_pkg::t_out r_out_row_count;
    nzcsb_pkg::t_out r_out_col_count;
    nzcsb_pkg::t_out r_out_rows_nz;
    nzcsb_pkg::t_out r_out_cols_nz;
    nzcsb_pkg::t_out r_out_max_row;
    nzcsb_pkg::t_out r_out_max_col;
    logic            r_out_error;

    logic            in_accept;
    logic            s1_fire;
    logic            in_ok;
    logic [RCW-1:0]  row_rdata;
    logic [CCW-1:0]  col_rdata;
    logic [RCW-1:0]  row_cur;
    logic [CCW-1:0]  col_cur;
    logic            row_bump;
    logic            col_bump;
    logic [RCW-1:0]  row_new;
    logic [CCW-1:0]  col_new;
    nzcsb_pkg::t_out n_rows_nz;
    nzcsb_pkg::t_out n_cols_nz;
    logic [RCW-1:0]  n_max_row;
    logic [CCW-1:0]  n_max_col;
    logic            pipe_we;
    logic            row_we;
    logic            col_we;
    logic [RAW-1:0]  row_waddr;
    logic [CAW-1:0]  col_waddr;
    logic [RCW-1:0]  row_wdata;
    logic [CCW-1:0]  col_wdata;

    assign s1_fire        = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_clearing && (!r_s1_valid || s1_fire);
    assign in_accept      = i_item.valid && i_item.ready;

    assign in_ok = ({1'b0, i_item.row_index} < r_rows_in_use)
                && (32'(i_item.row_index) < ROWS)
                && ({1'b0, i_item.col_index} < r_cols_in_use)
                && (32'(i_item.col_index) < COLS);

    // Read-modify-write of both counters.
    always_comb begin
        row_cur = (r_fwd_row_vld && r_fwd_row_addr == r_s1_row) ? r_fwd_row_data : row_rdata;
        col_cur = (r_fwd_col_vld && r_fwd_col_addr == r_s1_col) ? r_fwd_col_data : col_rdata;

        row_bump = r_s1_ok && (row_cur != ROW_BOUND);
        col_bump = r_s1_ok && (col_cur != COL_BOUND);
        row_new  = row_bump ? row_cur + RCW'(1) : row_cur;
        col_new  = col_bump ? col_cur + CCW'(1) : col_cur;

        n_rows_nz = r_rows_nz;
        if (row_bump && row_cur == '0) begin
            n_rows_nz = r_rows_nz + nzcsb_pkg::OUT_W'(1);
        end
        n_cols_nz = r_cols_nz;
        if (col_bump && col_cur == '0) begin
            n_cols_nz = r_cols_nz + nzcsb_pkg::OUT_W'(1);
        end
        n_max_row = (row_bump && row_new > r_max_row) ? row_new : r_max_row;
        n_max_col = (col_bump && col_new > r_max_col) ? col_new : r_max_col;
    end

    // RAM write ports are shared between the clearing pass and the update stage.
    assign pipe_we   = s1_fire && r_s1_ok;
    assign row_we    = r_clearing || pipe_we;
    assign col_we    = r_clearing || pipe_we;
    assign row_waddr = r_clearing ? r_clr_addr[RAW-1:0] : r_s1_row;
    assign col_waddr = r_clearing ? r_clr_addr[CAW-1:0] : r_s1_col;
    assign row_wdata = r_clearing ? '0 : row_new;
    assign col_wdata = r_clearing ? '0 : col_new;

    nzcsb_ram #(.WIDTH(RCW), .DEPTH(ROW_DEPTH)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (in_accept),
        .i_raddr (i_item.row_index[RAW-1:0]),
        .o_rdata (row_rdata)
    );

    nzcsb_ram #(.WIDTH(CCW), .DEPTH(COL_DEPTH)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_re    (in_accept),
        .i_raddr (i_item.col_index[CAW-1:0]),
        .o_rdata (col_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= nzcsb_pkg::CFG_RESET_VALUE;
            r_cols_in_use <= nzcsb_pkg::CFG_RESET_VALUE;
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_s1_valid    <= 1'b0;
            r_fwd_row_vld <= 1'b0;
            r_fwd_col_vld <= 1'b0;
            r_rows_nz     <= '0;
            r_cols_nz     <= '0;
            r_max_row     <= '0;
            r_max_col     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    nzcsb_pkg::CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_data;
                    nzcsb_pkg::CFG_COLS_IN_USE: r_cols_in_use <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + CLRW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end

            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (pipe_we) begin
                r_fwd_row_vld <= 1'b1;
                r_fwd_col_vld <= 1'b1;
            end

            if (s1_fire) begin
                r_rows_nz   <= n_rows_nz;
                r_cols_nz   <= n_cols_nz;
                r_max_row   <= n_max_row;
                r_max_col   <= n_max_col;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ok  <= in_ok;
            r_s1_row <= i_item.row_index[RAW-1:0];
            r_s1_col <= i_item.col_index[CAW-1:0];
        end
        if (pipe_we) begin
            r_fwd_row_addr <= r_s1_row;
            r_fwd_row_data <= row_new;
            r_fwd_col_addr <= r_s1_col;
            r_fwd_col_data <= col_new;
        end
        if (s1_fire) begin
            r_out_row_count <= r_s1_ok ? nzcsb_pkg::OUT_W'(row_new) : '0;
            r_out_col_count <= r_s1_ok ? nzcsb_pkg::OUT_W'(col_new) : '0;
            r_out_rows_nz   <= n_rows_nz;
            r_out_cols_nz   <= n_cols_nz;
            r_out_max_row   <= nzcsb_pkg::OUT_W'(n_max_row);
            r_out_max_col   <= nzcsb_pkg::OUT_W'(n_max_col);
            r_out_error     <= !r_s1_ok;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.row_count     = r_out_row_count;
    assign o_result.col_count     = r_out_col_count;
    assign o_result.rows_nonzero  = r_out_rows_nz;
    assign o_result.cols_nonzero  = r_out_cols_nz;
    assign o_result.max_row_count = r_out_max_row;
    assign o_result.max_col_count = r_out_max_col;
    assign o_result.index_error   = r_out_error;

endmodule

`default_nettype wire

/* hdl/nzcsb_checker.sv */
// Port-level checks for the sketch builder, bound to the top level.
// Depends on nzcsb_pkg and nonzero_count_sketch_builder_unit.
`default_nettype none

module nzcsb_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire nzcsb_pkg::t_out i_row_count,
    input wire nzcsb_pkg::t_out i_col_count,
    input wire nzcsb_pkg::t_out i_rows_nonzero,
    input wire nzcsb_pkg::t_out i_cols_nonzero,
    input wire logic            i_index_error
);

    // The count stores are being zeroed right after reset, so nothing is taken.
    a_no_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("input ready right after reset");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // A rejected item reports zero counts.
    a_error_zero_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_index_error) |-> (i_row_count == '0 && i_col_count == '0))
        else $error("index error with nonzero counts");

    // After an accepted entry at least one row and one column are nonzero.
    a_totals_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_index_error) |-> (i_rows_nonzero != '0 && i_cols_nonzero != '0))
        else $error("valid entry but zero totals");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_row_count) && $stable(i_rows_nonzero)))
        else $error("stalled result changed");

endmodule

bind nonzero_count_sketch_builder_unit nzcsb_checker u_nzcsb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_row_count    (o_result.row_count),
    .i_col_count    (o_result.col_count),
    .i_rows_nonzero (o_result.rows_nonzero),
    .i_cols_nonzero (o_result.cols_nonzero),
    .i_index_error  (o_result.index_error)
);

`default_nettype wire
